// File: rtl/core/tcsp_pkg.sv
// Package for the TTL cache slot policy unit.
// Holds widths, command codes and the payload and control struct types.
// Used by tcsp_store and ttl_cache_slot_policy_unit; depends on nothing.
package tcsp_pkg;

    localparam int KEY_W       = 64;
    localparam int TTL_W       = 7;
    localparam int SLOT_W      = 4;
    localparam int ENTRIES_DEF = 16;

    localparam logic [TTL_W-1:0] TTL_MAX   = '1;
    localparam logic [TTL_W-1:0] TTL_RESET = 7'd1;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key;
    } t_item;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_result;

    typedef struct packed {
        logic ttl_en;
        logic key_en;
    } t_wr_ctl;

endpackage

// File: rtl/core/tcsp_store.sv
// Slot store: synchronous TTL and key memories with registered read data.
// TTL entries carry valid bits so that never-written slots read as empty.
// Depends on tcsp_pkg.
module tcsp_store #(
    parameter int ENTRIES = tcsp_pkg::ENTRIES_DEF,
    parameter int IW      = $clog2(ENTRIES)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [IW-1:0]              i_rd_addr,
    output logic [tcsp_pkg::TTL_W-1:0] o_rd_ttl,
    output logic [tcsp_pkg::KEY_W-1:0] o_rd_key,
    input  tcsp_pkg::t_wr_ctl          i_wr_ctl,
    input  logic [IW-1:0]              i_wr_addr,
    input  logic [tcsp_pkg::TTL_W-1:0] i_wr_ttl,
    input  logic [tcsp_pkg::KEY_W-1:0] i_wr_key
);

    logic [tcsp_pkg::TTL_W-1:0] r_ttl_mem [ENTRIES];
    logic [tcsp_pkg::KEY_W-1:0] r_key_mem [ENTRIES];
    logic [ENTRIES-1:0]         r_vld;
    logic [tcsp_pkg::TTL_W-1:0] r_rd_ttl;
    logic [tcsp_pkg::KEY_W-1:0] r_rd_key;
    logic                       r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_ctl.ttl_en) begin
            r_ttl_mem[i_wr_addr] <= i_wr_ttl;
        end
        if (i_wr_ctl.key_en) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
        end
        r_rd_ttl <= r_ttl_mem[i_rd_addr];
        r_rd_key <= r_key_mem[i_rd_addr];
        r_rd_vld <= r_vld[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_ctl.ttl_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_ttl = r_rd_vld ? r_rd_ttl : '0;
    assign o_rd_key = r_rd_key;

endmodule

// File: rtl/core/ttl_cache_slot_policy_unit.sv
// Top level of the TTL cache slot policy unit: command port, scan control.
// Instantiates tcsp_store; depends on tcsp_pkg.
//
// The unit takes one command at a time and holds busy high while it works.
// A lookup or tick walks the slots in index order, one slot read per cycle
// from the slot store; a tick or a missing lookup occupies the unit until
// the last slot has been checked and busy falls, and a lookup that hits
// slot k frees it once slot k has been checked. A lookup gives one result
// transfer, strobed by o_valid for a single cycle as busy falls; the receiver
// must take it then, since it cannot stall the unit. A tick gives no result.
// The TTL start value may be written only while busy is low.
module ttl_cache_slot_policy_unit #(
    parameter int ENTRIES = tcsp_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  tcsp_pkg::t_item            i_item,
    output logic                       o_valid,
    output tcsp_pkg::t_result          o_result,
    input  logic                       i_cfg_we,
    input  logic [tcsp_pkg::TTL_W-1:0] i_cfg_wdata
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                       r_state, n_state;
    logic                       r_cmd, n_cmd;
    logic [tcsp_pkg::KEY_W-1:0] r_key, n_key;
    logic                       r_issue, n_issue;
    logic [IW-1:0]              r_idx, n_idx;
    logic                       r_dv, n_dv;
    logic [IW-1:0]              r_didx, n_didx;
    logic [tcsp_pkg::TTL_W-1:0] r_best, n_best;
    logic [IW-1:0]              r_victim, n_victim;
    logic [tcsp_pkg::TTL_W-1:0] r_ttl_start, n_ttl_start;
    logic                       r_strobe, n_strobe;
    tcsp_pkg::t_result          r_result, n_result;

    logic [tcsp_pkg::TTL_W-1:0] rd_ttl;
    logic [tcsp_pkg::KEY_W-1:0] rd_key;
    tcsp_pkg::t_wr_ctl          wr_ctl;
    logic [IW-1:0]              wr_addr;
    logic [tcsp_pkg::TTL_W-1:0] wr_ttl;
    logic [tcsp_pkg::TTL_W-1:0] cand_best;
    logic [IW-1:0]              cand_victim;
    logic                       live;
    logic                       last;

    tcsp_store #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (r_idx),
        .o_rd_ttl  (rd_ttl),
        .o_rd_key  (rd_key),
        .i_wr_ctl  (wr_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_ttl  (wr_ttl),
        .i_wr_key  (r_key)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_issue     = r_issue;
        n_idx       = r_idx;
        n_dv        = 1'b0;
        n_didx      = r_idx;
        n_best      = r_best;
        n_victim    = r_victim;
        n_ttl_start = r_ttl_start;
        n_strobe    = 1'b0;
        n_result    = r_result;
        wr_ctl      = '0;
        wr_addr     = r_didx;
        wr_ttl      = '0;
        live        = (rd_ttl != '0);
        last        = (r_didx == LAST_IDX);
        cand_best   = r_best;
        cand_victim = r_victim;

        if (i_cfg_we) begin
            n_ttl_start = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state  = S_SCAN;
                    n_cmd    = i_item.command;
                    n_key    = i_item.key;
                    n_idx    = '0;
                    n_issue  = 1'b1;
                    n_best   = tcsp_pkg::TTL_MAX;
                    n_victim = '0;
                end
            end
            S_SCAN: begin
                if (r_issue) begin
                    n_dv   = 1'b1;
                    n_didx = r_idx;
                    if (r_idx == LAST_IDX) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
                if (r_dv) begin
                    if (r_cmd == tcsp_pkg::CMD_TICK) begin
                        if (live) begin
                            wr_ctl.ttl_en = 1'b1;
                            wr_ttl        = rd_ttl - tcsp_pkg::TTL_W'(1);
                        end
                        if (last) begin
                            n_state = S_IDLE;
                        end
                    end else if (live && rd_key == r_key) begin
                        n_state         = S_IDLE;
                        n_issue         = 1'b0;
                        n_dv            = 1'b0;
                        n_strobe        = 1'b1;
                        n_result.hit    = 1'b1;
                        n_result.slot   = tcsp_pkg::SLOT_W'(r_didx);
                    end else begin
                        if (!live) begin
                            cand_best   = '0;
                            cand_victim = r_didx;
                        end else if (rd_ttl < r_best) begin
                            cand_best   = rd_ttl;
                            cand_victim = r_didx;
                        end
                        n_best   = cand_best;
                        n_victim = cand_victim;
                        if (last) begin
                            n_state       = S_IDLE;
                            wr_ctl.ttl_en = 1'b1;
                            wr_ctl.key_en = 1'b1;
                            wr_addr       = cand_victim;
                            wr_ttl        = r_ttl_start;
                            n_strobe      = 1'b1;
                            n_result.hit  = 1'b0;
                            n_result.slot = tcsp_pkg::SLOT_W'(cand_victim);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_dv        <= 1'b0;
            r_strobe    <= 1'b0;
            r_ttl_start <= tcsp_pkg::TTL_RESET;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_dv        <= n_dv;
            r_strobe    <= n_strobe;
            r_ttl_start <= n_ttl_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_didx   <= n_didx;
        r_best   <= n_best;
        r_victim <= n_victim;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_strobe;
    assign o_result = r_result;

    a_no_back_to_back_results : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe
    ) else $error("two result transfers in consecutive cycles");

    a_result_only_for_lookup : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_cmd == tcsp_pkg::CMD_LOOKUP)
    ) else $error("result transfer produced by a tick");

    a_write_needs_read_data : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (wr_ctl.ttl_en || wr_ctl.key_en) |-> (r_state == S_SCAN && r_dv)
    ) else $error("store written without slot data in hand");

    a_read_pipeline_order : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_dv && r_issue) |-> (r_idx == r_didx + IW'(1))
    ) else $error("read address out of step with checked slot");

    a_busy_after_accept : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy
    ) else $error("busy not raised after command transfer");

endmodule
